// ===== design/round_robin_thread_slot_scheduler_defines.svh =====
// Assertion macros for the scheduler checker.
`ifndef ROUND_ROBIN_THREAD_SLOT_SCHEDULER_DEFINES_SVH
`define ROUND_ROBIN_THREAD_SLOT_SCHEDULER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RRTS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RRTS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/rrts_pkg.sv =====
// Types and codes shared by the thread slot scheduler modules.
`timescale 1ns / 1ps

package rrts_pkg;

    // Action codes
    localparam logic [2:0] ACT_CREATE = 3'd0;
    localparam logic [2:0] ACT_YIELD  = 3'd1;
    localparam logic [2:0] ACT_TICK   = 3'd2;
    localparam logic [2:0] ACT_EXIT   = 3'd3;
    localparam logic [2:0] ACT_JOIN   = 3'd4;
    localparam logic [2:0] ACT_QUERY  = 3'd5;

    // Fault codes
    localparam logic [1:0] FLT_NONE     = 2'd0;
    localparam logic [1:0] FLT_SLOT0    = 2'd1;
    localparam logic [1:0] FLT_NO_READY = 2'd2;

    // Slot states
    typedef enum logic [1:0] {
        ST_FREE    = 2'd0,
        ST_READY   = 2'd1,
        ST_RUNNING = 2'd2,
        ST_EXITED  = 2'd3
    } slot_st_t;

    // Input beat
    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] target_id;
    } in_t;

    // Result beat
    typedef struct packed {
        logic        ok;
        logic [15:0] new_id;
        logic [1:0]  thread_status;
        logic [2:0]  running_slot;
        logic [15:0] running_id;
        logic        switched;
        logic [1:0]  fault;
    } out_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic write_a;
        logic write_b;
        logic finish;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_last;
    } status_t;

endpackage

// ===== design/round_robin_thread_slot_scheduler.sv =====
// Round-robin thread slot scheduler top level.
// Each action beat passes through an accept step, one slot table read per
// slot, a drain step for the last read data, two table writes and a step
// that loads the result. The result beat becomes valid in the same cycle
// that the next action can be accepted. The scan over the slot table, which
// has a single read port and a single write port, sets the length of each
// action. One action is in work at a time; the result sits in its own
// register, so the next action is accepted while an earlier result is still
// waiting to be taken, and that next action then holds in its final state
// until the waiting result is taken. No clearing pass follows reset: the
// table starts with slot 0 running as id 1.
`timescale 1ns / 1ps

module round_robin_thread_slot_scheduler import rrts_pkg::*; #(
    parameter int SLOT_COUNT = 8,
    parameter int ID_BITS    = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    cmd_t    cmd;
    status_t status;

    rrts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    rrts_dp #(
        .SLOT_COUNT (SLOT_COUNT),
        .ID_BITS    (ID_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .in_data  (in_data),
        .out_data (out_data)
    );

endmodule

// ===== design/rrts_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rrts_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and read one word per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/rrts_dp.sv =====
// Scheduler datapath: slot table, scan results, decision and result register.
`timescale 1ns / 1ps

module rrts_dp import rrts_pkg::*; #(
    parameter int SLOT_COUNT = 8,
    parameter int ID_BITS    = 16
) (
    input  logic    clk,
    input  logic    rst_n,
    input  cmd_t    cmd,
    output status_t status,
    input  in_t     in_data,
    output out_t    out_data
);

    localparam int SW = $clog2(SLOT_COUNT);
    localparam int DW = ID_BITS + 2;
    localparam int CW = (ID_BITS > 16) ? ID_BITS : 16;
    localparam logic [SW-1:0] LAST_SLOT = SW'(SLOT_COUNT - 1);

    // Captured beat
    logic [2:0]            act_reg;
    logic [15:0]           tgt_reg;

    // Scheduler state
    logic [SW-1:0]         run_idx_reg;
    logic [ID_BITS-1:0]    run_id_reg;
    logic [ID_BITS:0]      next_id_reg;
    logic [SLOT_COUNT-1:0] vld_reg;

    // Scan pipeline
    logic [SW-1:0]         scan_idx_reg;
    logic [SW-1:0]         rd_idx_reg;
    logic                  rd_on_reg;
    logic                  rd_vld_reg;

    // Scan results
    logic                  free_hit_reg;
    logic [SW-1:0]         free_idx_reg;
    logic                  hi_hit_reg;
    logic [SW-1:0]         hi_idx_reg;
    logic [ID_BITS-1:0]    hi_id_reg;
    logic                  lo_hit_reg;
    logic [SW-1:0]         lo_idx_reg;
    logic [ID_BITS-1:0]    lo_id_reg;
    logic                  m_hit_reg;
    logic [SW-1:0]         m_idx_reg;
    slot_st_t              m_st_reg;

    out_t                  out_reg;

    // RAM ports
    logic                  ram_we;
    logic [SW-1:0]         ram_waddr;
    logic [DW-1:0]         ram_wdata;
    logic [DW-1:0]         ram_rdata;

    // Decoded entry
    slot_st_t              ent_st;
    logic [ID_BITS-1:0]    ent_id;
    logic                  ent_match;

    // Decision
    logic                  nxt_hit;
    logic [SW-1:0]         nxt_idx;
    logic [ID_BITS-1:0]    nxt_id;
    logic                  switch_go;
    slot_st_t              old_st;
    logic                  wr_a_need;
    logic [SW-1:0]         wr_a_addr;
    logic [DW-1:0]         wr_a_data;
    logic                  ok_c;
    logic [15:0]           new_id_c;
    logic [1:0]            status_c;
    logic [1:0]            fault_c;
    logic                  ids_left;
    logic [SW-1:0]         run_idx_c;
    logic [ID_BITS-1:0]    run_id_c;

    rrts_ram #(
        .WIDTH (DW),
        .DEPTH (SLOT_COUNT)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (scan_idx_reg),
        .rdata (ram_rdata)
    );

    assign status.scan_last = (scan_idx_reg == LAST_SLOT);

    // Decode the word read back; an unwritten slot shows its reset contents
    always_comb
    begin
        if (rd_vld_reg)
        begin
            ent_st = slot_st_t'(ram_rdata[DW-1 -: 2]);
            ent_id = ram_rdata[ID_BITS-1:0];
        end
        else if (rd_idx_reg == '0)
        begin
            ent_st = ST_RUNNING;
            ent_id = ID_BITS'(1);
        end
        else
        begin
            ent_st = ST_FREE;
            ent_id = '0;
        end
        ent_match = (ent_st != ST_FREE) && (tgt_reg != 16'd0)
                    && (CW'(ent_id) == CW'(tgt_reg));
    end

    // Work out the effect of the captured action from the scan results
    always_comb
    begin
        nxt_hit   = hi_hit_reg | lo_hit_reg;
        nxt_idx   = hi_hit_reg ? hi_idx_reg : lo_idx_reg;
        nxt_id    = hi_hit_reg ? hi_id_reg : lo_id_reg;
        ids_left  = ~next_id_reg[ID_BITS];
        switch_go = 1'b0;
        old_st    = ST_READY;
        wr_a_need = 1'b0;
        wr_a_addr = free_idx_reg;
        wr_a_data = {ST_READY, next_id_reg[ID_BITS-1:0]};
        ok_c      = 1'b0;
        new_id_c  = 16'd0;
        status_c  = 2'd0;
        fault_c   = FLT_NONE;

        case (act_reg)
            ACT_CREATE:
            begin
                if (ids_left && free_hit_reg)
                begin
                    ok_c      = 1'b1;
                    wr_a_need = 1'b1;
                    new_id_c  = 16'(next_id_reg[ID_BITS-1:0]);
                end
            end
            ACT_YIELD, ACT_TICK:
            begin
                ok_c      = 1'b1;
                switch_go = nxt_hit;
            end
            ACT_EXIT:
            begin
                if (run_idx_reg == '0)
                begin
                    fault_c = FLT_SLOT0;
                end
                else if (!nxt_hit)
                begin
                    fault_c = FLT_NO_READY;
                end
                else
                begin
                    ok_c      = 1'b1;
                    switch_go = 1'b1;
                    old_st    = ST_EXITED;
                end
            end
            ACT_JOIN:
            begin
                if (m_hit_reg && (m_idx_reg != '0) && (m_idx_reg != run_idx_reg)
                    && (m_st_reg == ST_EXITED))
                begin
                    ok_c      = 1'b1;
                    wr_a_need = 1'b1;
                    wr_a_addr = m_idx_reg;
                    wr_a_data = {ST_FREE, {ID_BITS{1'b0}}};
                end
            end
            ACT_QUERY:
            begin
                if (m_hit_reg)
                begin
                    ok_c     = 1'b1;
                    status_c = m_st_reg;
                end
            end
            default:
            begin
                ok_c = 1'b0;
            end
        endcase

        // A switch first retires the running slot
        if (switch_go)
        begin
            wr_a_need = 1'b1;
            wr_a_addr = run_idx_reg;
            wr_a_data = {old_st, run_id_reg};
        end

        run_idx_c = switch_go ? nxt_idx : run_idx_reg;
        run_id_c  = switch_go ? nxt_id : run_id_reg;
    end

    // First write retires, fills or frees a slot, second one starts the new thread
    always_comb
    begin
        ram_we    = (cmd.write_a & wr_a_need) | (cmd.write_b & switch_go);
        ram_waddr = cmd.write_b ? nxt_idx : wr_a_addr;
        ram_wdata = cmd.write_b ? {ST_RUNNING, nxt_id} : wr_a_data;
    end

    // Hold scheduler state, scan pipeline and scan results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg      <= ACT_CREATE;
            tgt_reg      <= '0;
            run_idx_reg  <= '0;
            run_id_reg   <= ID_BITS'(1);
            next_id_reg  <= (ID_BITS + 1)'(2);
            vld_reg      <= '0;
            scan_idx_reg <= '0;
            rd_idx_reg   <= '0;
            rd_on_reg    <= 1'b0;
            rd_vld_reg   <= 1'b0;
            free_hit_reg <= 1'b0;
            free_idx_reg <= '0;
            hi_hit_reg   <= 1'b0;
            hi_idx_reg   <= '0;
            hi_id_reg    <= '0;
            lo_hit_reg   <= 1'b0;
            lo_idx_reg   <= '0;
            lo_id_reg    <= '0;
            m_hit_reg    <= 1'b0;
            m_idx_reg    <= '0;
            m_st_reg     <= ST_FREE;
        end
        else
        begin
            // Issue one slot read per scan cycle
            rd_on_reg  <= cmd.scan;
            rd_idx_reg <= scan_idx_reg;
            rd_vld_reg <= vld_reg[scan_idx_reg];

            if (cmd.load)
            begin
                act_reg      <= in_data.action;
                tgt_reg      <= in_data.target_id;
                scan_idx_reg <= '0;
                free_hit_reg <= 1'b0;
                hi_hit_reg   <= 1'b0;
                lo_hit_reg   <= 1'b0;
                m_hit_reg    <= 1'b0;
            end
            else if (cmd.scan)
            begin
                scan_idx_reg <= scan_idx_reg + SW'(1);
            end

            // Keep the first candidate of each kind
            if (rd_on_reg)
            begin
                if ((ent_st == ST_FREE) && (rd_idx_reg != '0) && !free_hit_reg)
                begin
                    free_hit_reg <= 1'b1;
                    free_idx_reg <= rd_idx_reg;
                end
                if ((ent_st == ST_READY) && (rd_idx_reg > run_idx_reg) && !hi_hit_reg)
                begin
                    hi_hit_reg <= 1'b1;
                    hi_idx_reg <= rd_idx_reg;
                    hi_id_reg  <= ent_id;
                end
                if ((ent_st == ST_READY) && (rd_idx_reg < run_idx_reg) && !lo_hit_reg)
                begin
                    lo_hit_reg <= 1'b1;
                    lo_idx_reg <= rd_idx_reg;
                    lo_id_reg  <= ent_id;
                end
                if (ent_match && !m_hit_reg)
                begin
                    m_hit_reg <= 1'b1;
                    m_idx_reg <= rd_idx_reg;
                    m_st_reg  <= ent_st;
                end
            end

            // Mark written slots as holding real contents
            if (ram_we)
            begin
                vld_reg[ram_waddr] <= 1'b1;
            end

            // Commit the running thread and the id counter
            if (cmd.finish)
            begin
                run_idx_reg <= run_idx_c;
                run_id_reg  <= run_id_c;
                if ((act_reg == ACT_CREATE) && ok_c)
                begin
                    next_id_reg <= next_id_reg + (ID_BITS + 1)'(1);
                end
            end
        end
    end

    // Load the result beat
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_reg.ok            <= ok_c;
            out_reg.new_id        <= new_id_c;
            out_reg.thread_status <= status_c;
            out_reg.running_slot  <= 3'(run_idx_c);
            out_reg.running_id    <= 16'(run_id_c);
            out_reg.switched      <= switch_go;
            out_reg.fault         <= fault_c;
        end
    end

    assign out_data = out_reg;

endmodule

// ===== design/rrts_ctrl.sv =====
// Scheduler controller: sequences accept, slot scan, table writes and result.
`timescale 1ns / 1ps

module rrts_ctrl import rrts_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output cmd_t    cmd,
    input  status_t status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_WR_A,
        S_WR_B,
        S_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // Work out the next step
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;

        // Drop the result once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_WR_A;
            end
            S_WR_A:
            begin
                cmd.write_a = 1'b1;
                state_next  = S_WR_B;
            end
            S_WR_B:
            begin
                cmd.write_b = 1'b1;
                state_next  = S_FIN;
            end
            S_FIN:
            begin
                // Wait until the result register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and the result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== design/rrts_chk.sv =====
// Port-level checker for the scheduler, bound to the top level.
`timescale 1ns / 1ps
`include "round_robin_thread_slot_scheduler_defines.svh"

module rrts_chk import rrts_pkg::*; (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input out_t out_data
);

    // A faulted action never reports success
    `RRTS_ASSERT_IMP(a_fault_not_ok, clk, rst_n, out_valid && (out_data.fault != FLT_NONE), !out_data.ok, "fault with ok set")

    // A switch only comes from a successful action
    `RRTS_ASSERT_IMP(a_switch_ok, clk, rst_n, out_valid && out_data.switched, out_data.ok && (out_data.fault == FLT_NONE), "switch without success")

    // A new id only appears on success
    `RRTS_ASSERT_IMP(a_new_id_ok, clk, rst_n, out_valid && (out_data.new_id != 16'd0), out_data.ok, "new id on failed action")

    // One action at a time: accepting closes the input side
    `RRTS_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready && !$rose(out_valid), "input open or result too early after accept")

    // A stalled result holds
    `RRTS_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")

endmodule

bind round_robin_thread_slot_scheduler rrts_chk u_rrts_chk (.*);
